>>> hw/rtl/pmftl_pkg.sv
// Shared types and codes for the page-mapped flash translation layer.
`timescale 1ns / 1ps
package pmftl_pkg;
  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_PROGRAM = 3'd1;
  localparam logic [2:0] OP_COPY    = 3'd2;
  localparam logic [2:0] OP_ERASE   = 3'd3;
  localparam logic [2:0] OP_ERROR   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_UNMAP   = 2'd2;
  localparam logic [1:0] ST_NOFREE  = 2'd3;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [3:0] {
    DC_NONE,
    DC_LOAD,
    DC_MAP_RD,
    DC_SCAN_START,
    DC_SCAN_STEP,
    DC_GC_START,
    DC_GC_RD,
    DC_GC_STEP,
    DC_GC_ERASE,
    DC_CLR_OLD,
    DC_PROGRAM
  } dp_cmd_e;

  typedef struct packed {
    logic       scan_done;
    logic       scan_found;
    logic       gc_done;
    logic       gc_copy;
    logic       in_range;
    logic       old_mapped;
    logic       clear_done;
  } dp_status_t;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] target_page;
    logic [6:0] source_page;
    logic [3:0] erase_block;
    logic [1:0] status;
    logic       last;
  } result_t;
endpackage

>>> hw/rtl/pmftl_datapath.sv
// Datapath: map, valid and owner stores, free scanner and collection walker.
`timescale 1ns / 1ps
module pmftl_datapath import pmftl_pkg::*; #(
  parameter int PAGES_IN_BLOCK = 8,
  parameter int BLOCK_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_e    cmd,
  input  logic [6:0] lp_in,
  output dp_status_t st,
  output result_t    res
);
  localparam int PT = PAGES_IN_BLOCK * BLOCK_COUNT;
  localparam int LT = (BLOCK_COUNT - 1) * PAGES_IN_BLOCK;
  localparam int PW = $clog2(PT);
  localparam int OW = $clog2(PAGES_IN_BLOCK);
  localparam int BW = $clog2(BLOCK_COUNT);
  localparam int LW = $clog2(LT);

  // map memory with fill-free validity: one mapped bit per logical page
  logic [PW-1:0] map_mem [LT];
  logic [LT-1:0] map_ok_r;
  logic [PT-1:0] valid_r;
  logic [PW-1:0] owner_mem [PT];

  logic [6:0]    lp_r;
  logic [PW-1:0] old_r, map_rd_r, scan_r, free_r;
  logic          old_ok_r, found_r, scan_done_r;
  logic [BW-1:0] spare_r, victim_r;
  logic [OW:0]   j_r;
  logic          gc_copy_r;
  logic [PW-1:0] own_rd_r;
  logic          own_pend_r;
  logic [PW-1:0] gs, gd;

  logic [LW-1:0] lpi;
  assign lpi = lp_r[LW-1:0];
  assign gs = PW'({victim_r, j_r[OW-1:0]});
  assign gd = PW'({spare_r, j_r[OW-1:0]});

  assign st.in_range   = (32'(lp_r) < LT);
  assign st.old_mapped = old_ok_r;
  assign st.scan_done  = scan_done_r;
  assign st.scan_found = found_r;
  // high while the walker sits on the last page of the victim block
  assign st.gc_done    = (32'(j_r) == PAGES_IN_BLOCK - 1);
  assign st.gc_copy    = gc_copy_r;
  assign st.clear_done = 1'b1;

  always_ff @(posedge clk) begin
    if (cmd == DC_LOAD) lp_r <= lp_in;
    if (cmd == DC_MAP_RD) begin
      map_rd_r <= map_mem[lpi];
    end
    if (cmd == DC_GC_RD) own_rd_r <= owner_mem[gs];
    if (cmd == DC_GC_STEP && gc_copy_r) begin
      owner_mem[gd] <= own_rd_r;
      if (32'(own_rd_r) < LT) map_mem[own_rd_r[LW-1:0]] <= gd;
    end
    if (cmd == DC_PROGRAM) begin
      owner_mem[free_r] <= PW'(lp_r);
      map_mem[lpi] <= free_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_ok_r <= '0;
      valid_r <= '0;
      spare_r <= BW'(BLOCK_COUNT - 1);
      old_ok_r <= 1'b0;
      scan_done_r <= 1'b0;
      found_r <= 1'b0;
      gc_copy_r <= 1'b0;
      j_r <= '0;
      scan_r <= '0;
      free_r <= '0;
      old_r <= '0;
      victim_r <= '0;
      own_pend_r <= 1'b0;
    end else begin
      own_pend_r <= 1'b0;
      unique case (cmd)
        DC_MAP_RD: old_ok_r <= map_ok_r[lpi];
        DC_SCAN_START: begin
          old_r <= map_rd_r;
          scan_r <= '0;
          scan_done_r <= 1'b0;
          found_r <= 1'b0;
        end
        DC_SCAN_STEP: begin
          if (!scan_done_r) begin
            if (32'(scan_r) / PAGES_IN_BLOCK != 32'(spare_r) && !valid_r[scan_r]) begin
              found_r <= 1'b1;
              free_r <= scan_r;
              scan_done_r <= 1'b1;
            end else if (32'(scan_r) == PT - 1) begin
              scan_done_r <= 1'b1;
            end else begin
              scan_r <= scan_r + 1'b1;
            end
          end
        end
        DC_GC_START: begin
          victim_r <= BW'(32'(old_r) / PAGES_IN_BLOCK);
          j_r <= '0;
        end
        DC_GC_RD: begin
          gc_copy_r <= (gs != old_r) && valid_r[gs];
          own_pend_r <= 1'b1;
        end
        DC_GC_STEP: begin
          valid_r[gd] <= gc_copy_r;
          valid_r[gs] <= 1'b0;
          j_r <= j_r + 1'b1;
        end
        DC_GC_ERASE: spare_r <= victim_r;
        DC_CLR_OLD: if (old_ok_r) valid_r[old_r] <= 1'b0;
        DC_PROGRAM: begin
          valid_r[free_r] <= 1'b1;
          map_ok_r[lpi] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res = '0;
    res.target_page = 7'(map_rd_r);
    res.source_page = 7'(gs);
    res.erase_block = 4'(victim_r);
    if (cmd == DC_GC_STEP) begin
      res.target_page = 7'(gd);
    end else if (cmd == DC_PROGRAM) begin
      res.target_page = 7'(free_r);
    end
    res.op = OP_READ;
    res.status = ST_OK;
    res.last = own_pend_r;
  end
endmodule

>>> hw/rtl/pmftl_ctrl.sv
// Controller: sequences reads, free scans, collection and result emission.
`timescale 1ns / 1ps
module pmftl_ctrl import pmftl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       in_cmd,
  input  logic       out_busy,
  input  dp_status_t st,
  input  result_t    dres,
  output logic       idle,
  output dp_cmd_e    cmd,
  output logic       emit,
  output result_t    res
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MAP = 4'd1, S_DEC = 4'd2, S_SCAN0 = 4'd3,
    S_SCAN = 4'd4, S_GC0 = 4'd5, S_GCRD = 4'd6, S_GCST = 4'd7, S_ERASE = 4'd8,
    S_SCAN1 = 4'd9, S_SCAN2 = 4'd10, S_CLR = 4'd11, S_PROG = 4'd12, S_ERR = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       cmd_r, cmd_nxt, gc_r, gc_nxt;
  logic [1:0] err_r, err_nxt;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    gc_nxt = gc_r;
    err_nxt = err_r;
    cmd = DC_NONE;
    emit = 1'b0;
    res = '0;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        cmd = DC_LOAD; cmd_nxt = in_cmd; gc_nxt = 1'b0; state_nxt = S_MAP;
      end
      S_MAP: begin cmd = DC_MAP_RD; state_nxt = S_DEC; end
      S_DEC: begin
        if (!st.in_range) begin err_nxt = ST_RANGE; state_nxt = S_ERR; end
        else if (cmd_r == CMD_READ) begin
          if (!st.old_mapped) begin err_nxt = ST_UNMAP; state_nxt = S_ERR; end
          else if (!out_busy) begin
            emit = 1'b1; res.op = OP_READ; res.target_page = dres.target_page;
            res.last = 1'b1; state_nxt = S_IDLE;
          end
        end else begin cmd = DC_SCAN_START; state_nxt = S_SCAN; end
      end
      S_SCAN: begin
        if (st.scan_done) begin
          if (st.scan_found) state_nxt = S_CLR;
          else if (gc_r) begin err_nxt = ST_NOFREE; state_nxt = S_ERR; end
          else if (!st.old_mapped) begin err_nxt = ST_NOFREE; state_nxt = S_ERR; end
          else begin cmd = DC_GC_START; gc_nxt = 1'b1; state_nxt = S_GCRD; end
        end else cmd = DC_SCAN_STEP;
      end
      S_GCRD: begin cmd = DC_GC_RD; state_nxt = S_GCST; end
      S_GCST: if (!(st.gc_copy && out_busy)) begin
        cmd = DC_GC_STEP;
        if (st.gc_copy) begin
          emit = 1'b1; res.op = OP_COPY; res.target_page = dres.target_page;
          res.source_page = dres.source_page;
        end
        state_nxt = st.gc_done ? S_ERASE : S_GCRD;
      end
      S_ERASE: if (!out_busy) begin
        cmd = DC_GC_ERASE; emit = 1'b1; res.op = OP_ERASE;
        res.erase_block = dres.erase_block; state_nxt = S_SCAN1;
      end
      S_SCAN1: begin cmd = DC_SCAN_START; state_nxt = S_SCAN; end
      S_CLR: begin cmd = DC_CLR_OLD; state_nxt = S_PROG; end
      S_PROG: if (!out_busy) begin
        cmd = DC_PROGRAM; emit = 1'b1; res.op = OP_PROGRAM;
        res.target_page = dres.target_page; res.last = 1'b1; state_nxt = S_IDLE;
      end
      S_ERR: if (!out_busy) begin
        emit = 1'b1; res.op = OP_ERROR; res.status = err_r; res.last = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cmd_r <= 1'b0; gc_r <= 1'b0; err_r <= ST_OK;
    end else begin
      state_r <= state_nxt; cmd_r <= cmd_nxt; gc_r <= gc_nxt; err_r <= err_nxt;
    end
  end
endmodule

>>> hw/rtl/page_mapped_ftl_with_gc.sv
// Top level of the page-mapped flash translation layer with collection.
`timescale 1ns / 1ps
// Takes one request word at a time. A write scans physical pages one per cycle
// for the first free page; when none is free and the old page is mapped,
// collection walks the victim block (the block of the old page) page by page,
// copying each still-valid page, erases it and rescans. Results leave
// through an output register, so the next request may be taken while the
// last result of the previous one waits.
module page_mapped_ftl_with_gc import pmftl_pkg::*; #(
  parameter int PAGES_IN_BLOCK = 8,
  parameter int BLOCK_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // logical_page[6:0]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // op, target_page, source_page, erase_block, status
  output logic        out_tlast   // last
);
  dp_cmd_e    cmd;
  dp_status_t st;
  result_t    dres, cres, out_r;
  logic       idle, emit, busy, vld_r;

  assign busy = vld_r && !out_tready;
  assign in_tready = idle;

  pmftl_datapath #(.PAGES_IN_BLOCK(PAGES_IN_BLOCK), .BLOCK_COUNT(BLOCK_COUNT)) u_dp (
    .clk, .rst_n, .cmd, .lp_in(in_tdata[6:0]), .st, .res(dres)
  );

  pmftl_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(in_tvalid && in_tready), .in_cmd(in_tuser),
    .out_busy(busy), .st, .dres, .idle, .cmd, .emit, .res(cres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (emit) vld_r <= 1'b1;
    else if (out_tready) vld_r <= 1'b0;
    if (emit) out_r <= cres;
  end

  assign out_tvalid = vld_r;
  assign out_tdata = {1'b0, out_r.status, out_r.erase_block, out_r.source_page,
                      out_r.target_page, out_r.op};
  assign out_tlast = out_r.last;
endmodule
